// ===== hw/rtl/rrtp_pkg.sv =====
// rrtp_pkg: shared constants, command/status structs and helpers for the
// round-robin thread picker; no dependencies
package rrtp_pkg;

  localparam int MAX_THREADS = 16;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  localparam int TID_W   = 4;
  localparam int KIND_W  = 3;
  localparam int TIME_W  = 64;
  localparam int SLICE_W = 32;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 32'd1000;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clr_res;
    logic do_add;
    logic do_set;
    logic clr_issue;
    logic clr_finish;
    logic sched_start;
    logic rm_step;
    logic scan_step;
    logic out_load;
  } rrtp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  count;
    logic              rm_go;
    logic              found;
    logic              out_free;
  } rrtp_sts_t;

  function automatic logic [IDX_W-1:0] to_idx(input logic [TID_W-1:0] id);
    logic [31:0] t;
    t = 32'(id);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic id_in_range(input logic [TID_W-1:0] id);
    return 32'(id) < 32'(MAX_THREADS);
  endfunction

endpackage

// ===== hw/rtl/rrtp_ifs.sv =====
// rrtp_ifs: valid/ready channel interfaces for request and result words
// depends on rrtp_pkg
interface rrtp_in_if;
  logic                         valid;
  logic                         ready;
  logic [rrtp_pkg::KIND_W-1:0]  kind;
  logic [rrtp_pkg::TID_W-1:0]   thread_id;
  logic                         prev_valid;
  logic [rrtp_pkg::TIME_W-1:0]  deadline;
  logic [rrtp_pkg::TIME_W-1:0]  now;

  modport source (output valid, kind, thread_id, prev_valid, deadline, now, input ready);
  modport sink   (input valid, kind, thread_id, prev_valid, deadline, now, output ready);
endinterface

interface rrtp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         chosen_valid;
  logic [rrtp_pkg::TID_W-1:0]   chosen_thread;
  logic [rrtp_pkg::TIME_W-1:0]  wait_ticks;
  logic                         was_delayed;
  logic                         refused;

  modport source (output valid, chosen_valid, chosen_thread, wait_ticks, was_delayed,
                  refused, input ready);
  modport sink   (input valid, chosen_valid, chosen_thread, wait_ticks, was_delayed,
                  refused, output ready);
endinterface

// ===== hw/rtl/round_robin_thread_picker.sv =====
// round_robin_thread_picker: top level of the round-robin thread picker
// depends on rrtp_pkg, rrtp_ifs, rrtp_ctrl and rrtp_datapath
//
// Round-robin picker over up to 16 threads: a FIFO ring of thread ids plus a
// 64-bit wake time and a running mark per thread. Each request word (add,
// remove, set deadline, clear deadline, schedule) gives exactly one result
// word. One request is worked on at a time. Clear deadline takes one
// wake-memory read. Remove of a queued thread walks the whole ring, N
// entries where N is the ring length; schedule visits k ring entries (0
// for an empty ring, at most N). The walk goes from the head one entry a
// cycle through the single wake-memory read port, rotating each visited
// entry to the tail and stopping at the first runnable one. The input is
// ready again in the same cycle the result word appears in the output
// register, so the next request is taken while the result waits; a
// request whose result is done while the previous word is still untaken
// holds in its finish step until that word is taken. slice_ticks is to be
// written via cfg_we/cfg_wdata only while idle; the block itself does not
// enforce this. It resets to 1000.
module round_robin_thread_picker (
  input  logic                          clk,
  input  logic                          rst_n,
  rrtp_in_if.sink                       in_ch,
  rrtp_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [rrtp_pkg::SLICE_W-1:0]  cfg_wdata
);

  // command and status between sequencer and datapath
  rrtp_pkg::rrtp_cmd_t cmd;
  rrtp_pkg::rrtp_sts_t sts;

  // sequencer: owns the input handshake and the walk counters
  rrtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: ring, marks, wake memory, result and output word registers
  rrtp_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_ch.kind),
    .in_thread_id      (in_ch.thread_id),
    .in_prev_valid     (in_ch.prev_valid),
    .in_deadline       (in_ch.deadline),
    .in_now            (in_ch.now),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_chosen_valid  (out_ch.chosen_valid),
    .out_chosen_thread (out_ch.chosen_thread),
    .out_wait_ticks    (out_ch.wait_ticks),
    .out_was_delayed   (out_ch.was_delayed),
    .out_refused       (out_ch.refused)
  );

endmodule

// ===== hw/rtl/rrtp_datapath.sv =====
// rrtp_datapath: thread ring, marks, wake-time memory, result and output registers
// depends on rrtp_pkg; driven by rrtp_ctrl through rrtp_cmd_t
module rrtp_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrtp_pkg::rrtp_cmd_t           cmd,
  output rrtp_pkg::rrtp_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [rrtp_pkg::SLICE_W-1:0]  cfg_wdata,
  input  logic [rrtp_pkg::KIND_W-1:0]   in_kind,
  input  logic [rrtp_pkg::TID_W-1:0]    in_thread_id,
  input  logic                          in_prev_valid,
  input  logic [rrtp_pkg::TIME_W-1:0]   in_deadline,
  input  logic [rrtp_pkg::TIME_W-1:0]   in_now,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_chosen_valid,
  output logic [rrtp_pkg::TID_W-1:0]    out_chosen_thread,
  output logic [rrtp_pkg::TIME_W-1:0]   out_wait_ticks,
  output logic                          out_was_delayed,
  output logic                          out_refused
);

  localparam int N = rrtp_pkg::MAX_THREADS;

  // latched request word
  logic [rrtp_pkg::KIND_W-1:0]  kind_r;
  logic [rrtp_pkg::TID_W-1:0]   id_r;
  logic                         prev_r;
  logic [rrtp_pkg::TIME_W-1:0]  dl_r;
  logic [rrtp_pkg::TIME_W-1:0]  now_r;
  logic [rrtp_pkg::SLICE_W-1:0] slice_r;

  logic [rrtp_pkg::TID_W-1:0]   ring_r   [N];
  logic [rrtp_pkg::TID_W-1:0]   ring_nxt [N];
  logic [rrtp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [N-1:0]                 queued_r, queued_nxt;
  logic [N-1:0]                 running_r, running_nxt;

  logic [rrtp_pkg::TIME_W-1:0]  wake_mem [N];
  logic [N-1:0]                 wake_vld_r;
  logic [rrtp_pkg::TIME_W-1:0]  rd_data_r;
  logic                         rd_vld_r;
  logic                         wr_en;
  logic [rrtp_pkg::IDX_W-1:0]   wr_idx, rd_idx;
  logic [rrtp_pkg::TIME_W-1:0]  wr_data;

  logic                         res_cv_r;
  logic [rrtp_pkg::TID_W-1:0]   res_ct_r;
  logic [rrtp_pkg::TIME_W-1:0]  res_wait_r;
  logic                         res_wd_r;
  logic                         res_ref_r;
  logic                         out_valid_r;

  logic                         id_ok;
  logic [rrtp_pkg::IDX_W-1:0]   idx;
  logic [rrtp_pkg::TID_W-1:0]   head_t;
  logic [rrtp_pkg::IDX_W-1:0]   head_idx;
  logic                         head_ok;
  logic [rrtp_pkg::TIME_W-1:0]  rd_val;
  logic [rrtp_pkg::TIME_W:0]    diff;
  logic                         later;
  logic                         eligible;
  logic                         pick;
  logic                         refuse;
  logic                         drop;
  logic                         shift;
  logic                         rotate;

  assign id_ok    = rrtp_pkg::id_in_range(id_r);
  assign idx      = rrtp_pkg::to_idx(id_r);
  assign head_t   = ring_r[0];
  assign head_idx = rrtp_pkg::to_idx(head_t);
  assign head_ok  = rrtp_pkg::id_in_range(head_t);
  assign rd_val   = rd_vld_r ? rd_data_r : '0;

  // borrow out of wake - now tells whether the wake time lies in the past
  assign diff     = {1'b0, rd_val} - {1'b0, now_r};
  assign later    = !diff[rrtp_pkg::TIME_W] && (diff[rrtp_pkg::TIME_W-1:0] != '0);
  assign eligible = head_ok && !running_r[head_idx] && !later;
  assign pick     = cmd.scan_step && eligible;

  assign refuse = !id_ok || queued_r[idx] || (cnt_r >= rrtp_pkg::CNT_W'(N));
  assign drop   = cmd.rm_step && (head_t == id_r);
  assign shift  = cmd.rm_step || cmd.scan_step;
  assign rotate = cmd.scan_step || (cmd.rm_step && !drop);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      id_r   <= in_thread_id;
      prev_r <= in_prev_valid;
      dl_r   <= in_deadline;
      now_r  <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= rrtp_pkg::SLICE_RESET;
    end else if (cfg_we) begin
      slice_r <= cfg_wdata;
    end
  end

  // ring update: append, or one step of head-to-tail rotation / head drop
  always_comb begin
    ring_nxt    = ring_r;
    cnt_nxt     = cnt_r;
    queued_nxt  = queued_r;
    running_nxt = running_r;
    if (cmd.do_add && !refuse) begin
      for (int k = 0; k < N; k++) begin
        if (rrtp_pkg::CNT_W'(k) == cnt_r) begin
          ring_nxt[k] = id_r;
        end
      end
      cnt_nxt         = cnt_r + 1'b1;
      queued_nxt[idx] = 1'b1;
    end
    if (shift) begin
      for (int k = 0; k < N - 1; k++) begin
        ring_nxt[k] = ring_r[k+1];
      end
      ring_nxt[N-1] = ring_r[N-1];
      if (rotate) begin
        for (int k = 0; k < N; k++) begin
          if (rrtp_pkg::CNT_W'(k) == cnt_r - 1'b1) begin
            ring_nxt[k] = ring_r[0];
          end
        end
      end
    end
    if (drop) begin
      cnt_nxt         = cnt_r - 1'b1;
      queued_nxt[idx] = 1'b0;
    end
    if (cmd.sched_start && prev_r && id_ok) begin
      running_nxt[idx] = 1'b0;
    end
    if (pick) begin
      running_nxt[head_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ring_r <= ring_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      queued_r  <= '0;
      running_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      queued_r  <= queued_nxt;
      running_r <= running_nxt;
    end
  end

  // wake-time memory: one write, one registered read per cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = idx;
    wr_data = '0;
    if (cmd.do_set && id_ok) begin
      wr_en   = 1'b1;
      wr_data = dl_r;
    end else if (cmd.clr_finish && id_ok) begin
      wr_en = 1'b1;
    end else if (pick) begin
      wr_en  = 1'b1;
      wr_idx = head_idx;
    end
  end

  always_comb begin
    if (cmd.clr_issue) begin
      rd_idx = idx;
    end else if (cmd.sched_start) begin
      rd_idx = head_idx;
    end else begin
      rd_idx = rrtp_pkg::to_idx(ring_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wake_mem[wr_idx] <= wr_data;
    end
    rd_data_r <= wake_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        wake_vld_r[wr_idx] <= 1'b1;
      end
      rd_vld_r <= wake_vld_r[rd_idx];
    end
  end

  // result fields collected while the operation runs
  // dispatch clears them, seeding the refusal and the slice cap where they apply
  always_ff @(posedge clk) begin
    if (cmd.clr_res) begin
      res_cv_r   <= 1'b0;
      res_ct_r   <= '0;
      res_wait_r <= cmd.sched_start ? rrtp_pkg::TIME_W'(slice_r) : '0;
      res_wd_r   <= 1'b0;
      res_ref_r  <= cmd.do_add ? refuse : 1'b0;
    end
    if (cmd.clr_finish) begin
      res_wd_r <= id_ok && (rd_val != '0);
    end
    if (pick) begin
      res_cv_r <= 1'b1;
      res_ct_r <= head_t;
    end else if (cmd.scan_step && head_ok && !running_r[head_idx] && later &&
                 (diff[rrtp_pkg::TIME_W-1:0] < res_wait_r)) begin
      res_wait_r <= diff[rrtp_pkg::TIME_W-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chosen_valid  <= res_cv_r;
      out_chosen_thread <= res_ct_r;
      out_wait_ticks    <= res_wait_r;
      out_was_delayed   <= res_wd_r;
      out_refused       <= res_ref_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.kind     = kind_r;
  assign sts.count    = cnt_r;
  assign sts.rm_go    = id_ok && queued_r[idx];
  assign sts.found    = eligible;
  assign sts.out_free = !out_valid_r || out_ready;

  a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == int'(cnt_r))
    else $error("queue count disagrees with queued marks");

  a_pick_marks_running: assert property (@(posedge clk) disable iff (!rst_n)
    pick |=> running_r[$past(head_idx)])
    else $error("picked thread not marked running");

  a_scan_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |=> cnt_r == $past(cnt_r))
    else $error("scan step changed queue length");

endmodule

// ===== hw/rtl/rrtp_ctrl.sv =====
// rrtp_ctrl: operation sequencer for the thread picker
// depends on rrtp_pkg; drives rrtp_datapath through rrtp_cmd_t
module rrtp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rrtp_pkg::rrtp_sts_t  sts,
  output rrtp_pkg::rrtp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_CLR,
    S_REMOVE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                     state_r;
  logic                       in_ready_r;
  logic [rrtp_pkg::CNT_W-1:0] steps_r;
  logic                       last_step;

  assign last_step = steps_r == rrtp_pkg::CNT_W'(1);
  assign in_ready  = in_ready_r;

  always_comb begin
    cmd       = '0;
    cmd.latch = in_ready_r && in_valid;
    case (state_r)
      S_DISP: begin
        cmd.clr_res = 1'b1;
        case (sts.kind)
          rrtp_pkg::KIND_ADD:    cmd.do_add      = 1'b1;
          rrtp_pkg::KIND_SET:    cmd.do_set      = 1'b1;
          rrtp_pkg::KIND_CLEAR:  cmd.clr_issue   = 1'b1;
          rrtp_pkg::KIND_SCHED:  cmd.sched_start = 1'b1;
          default: ;
        endcase
      end
      S_CLR:    cmd.clr_finish = 1'b1;
      S_REMOVE: cmd.rm_step    = 1'b1;
      S_SCAN:   cmd.scan_step  = 1'b1;
      S_FINISH: cmd.out_load   = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
      steps_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.latch) begin
            state_r    <= S_DISP;
            in_ready_r <= 1'b0;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        S_DISP: begin
          case (sts.kind)
            rrtp_pkg::KIND_REMOVE: begin
              if (sts.rm_go) begin
                steps_r <= sts.count;
                state_r <= S_REMOVE;
              end else begin
                state_r <= S_FINISH;
              end
            end
            rrtp_pkg::KIND_CLEAR: state_r <= S_CLR;
            rrtp_pkg::KIND_SCHED: begin
              if (sts.count == '0) begin
                state_r <= S_FINISH;
              end else begin
                steps_r <= sts.count;
                state_r <= S_SCAN;
              end
            end
            default: state_r <= S_FINISH;
          endcase
        end
        S_CLR: state_r <= S_FINISH;
        S_REMOVE: begin
          steps_r <= steps_r - 1'b1;
          if (last_step) begin
            state_r <= S_FINISH;
          end
        end
        S_SCAN: begin
          steps_r <= steps_r - 1'b1;
          if (sts.found || last_step) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_REMOVE) |-> (steps_r != '0 && steps_r <= sts.count))
    else $error("walk step count out of range");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending word");

  a_finish_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && sts.out_free) |=> in_ready_r)
    else $error("input not reopened after result handoff");

endmodule

// ===== tb/tb_round_robin_thread_picker.sv =====
// tb_round_robin_thread_picker: self-checking bench for the round-robin thread picker
// drives request words, predicts every result word and compares them field by field
// depends on rrtp_pkg, rrtp_ifs and round_robin_thread_picker
`timescale 1ns / 1ps

module tb_round_robin_thread_picker;

  // codes the block has no operation for
  localparam logic [rrtp_pkg::KIND_W-1:0] KIND_RSVD5 = 3'd5;
  localparam logic [rrtp_pkg::KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [rrtp_pkg::KIND_W-1:0] KIND_RSVD7 = 3'd7;

  localparam int IDLE_PCT      = 6;       // idle cycles per hundred, each side
  localparam int SETTLE_CYCLES = 24;      // covers the longest walk over all 16 ring entries plus turnaround
  localparam int CYCLE_LIMIT   = 300000;  // far beyond the slowest correct run
  localparam int RANDOM_WORDS  = 350;     // per random phase

  // where a schedule word takes its previously running thread from
  typedef enum logic [1:0] {
    PREV_AS_GIVEN,   // random fields as generated
    PREV_LAST_PICK,  // the thread the last schedule handed out
    PREV_ANY_BUSY    // any thread currently marked running
  } prev_src_t;

  typedef struct packed {
    logic [rrtp_pkg::KIND_W-1:0] kind;
    logic [rrtp_pkg::TID_W-1:0]  thread_id;
    logic                        prev_valid;
    logic [rrtp_pkg::TIME_W-1:0] deadline;
    logic [rrtp_pkg::TIME_W-1:0] now;
    prev_src_t                   prev_src;
  } pick_req_t;

  typedef struct packed {
    logic                        chosen_valid;
    logic [rrtp_pkg::TID_W-1:0]  chosen_thread;
    logic [rrtp_pkg::TIME_W-1:0] wait_ticks;
    logic                        was_delayed;
    logic                        refused;
  } pick_res_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [rrtp_pkg::SLICE_W-1:0] cfg_wdata = '0;

  rrtp_in_if  in_ch ();
  rrtp_out_if out_ch ();

  round_robin_thread_picker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow state of the picker, matching the block after reset
  logic [rrtp_pkg::TID_W-1:0]   ring_ids [rrtp_pkg::MAX_THREADS] = '{default: '0};
  int                           ring_len = 0;
  logic [rrtp_pkg::TIME_W-1:0]  wake_at  [rrtp_pkg::MAX_THREADS] = '{default: '0};
  logic                         running  [rrtp_pkg::MAX_THREADS] = '{default: 1'b0};
  logic                         queued   [rrtp_pkg::MAX_THREADS] = '{default: 1'b0};
  logic [rrtp_pkg::SLICE_W-1:0] slice_len = rrtp_pkg::SLICE_RESET;

  pick_req_t pending_reqs [$];    // request words not yet driven
  pick_res_t expected_words [$];  // result words still owed by the block
  pick_req_t in_flight;           // word currently offered on the input channel

  logic                        have_pick = 1'b0;
  logic [rrtp_pkg::TID_W-1:0]  last_pick = '0;
  logic [rrtp_pkg::TIME_W-1:0] t_base = '0;  // rough wall clock for the schedule words
  bit                          calm_stretch = 1'b0;
  int                          mismatch_count = 0;
  int                          cycle_count = 0;

  // apply one accepted request word to the shadow state, return its result word
  function automatic pick_res_t predict_picker_word(input pick_req_t r);
    pick_res_t                   res;
    logic [rrtp_pkg::TID_W-1:0]  rotated [rrtp_pkg::MAX_THREADS];
    logic [rrtp_pkg::TID_W-1:0]  t;
    logic [rrtp_pkg::TIME_W-1:0] gap;
    int                          hit;
    int                          n;
    res = '0;
    case (r.kind)
      rrtp_pkg::KIND_ADD: begin
        // ids are always below MAX_THREADS here, so only duplicates and a full ring refuse
        if (queued[r.thread_id] || ring_len >= rrtp_pkg::MAX_THREADS) begin
          res.refused = 1'b1;
        end else begin
          ring_ids[ring_len] = r.thread_id;
          ring_len++;
          queued[r.thread_id] = 1'b1;
        end
      end
      rrtp_pkg::KIND_REMOVE: begin
        // running mark survives the unlink
        if (queued[r.thread_id]) begin
          n = 0;
          for (int k = 0; k < ring_len; k++) begin
            if (ring_ids[k] != r.thread_id) begin
              ring_ids[n] = ring_ids[k];
              n++;
            end
          end
          ring_len = n;
          queued[r.thread_id] = 1'b0;
        end
      end
      rrtp_pkg::KIND_SET: wake_at[r.thread_id] = r.deadline;
      rrtp_pkg::KIND_CLEAR: begin
        res.was_delayed = wake_at[r.thread_id] != '0;
        wake_at[r.thread_id] = '0;
      end
      rrtp_pkg::KIND_SCHED: begin
        if (r.prev_valid) running[r.thread_id] = 1'b0;
        res.wait_ticks = rrtp_pkg::TIME_W'(slice_len);
        hit = -1;
        // first idle thread whose wake time has come; later entries are never looked at
        for (int k = 0; k < ring_len; k++) begin
          t = ring_ids[k];
          if (hit < 0 && !running[t]) begin
            if (wake_at[t] > r.now) begin
              gap = wake_at[t] - r.now;
              if (gap < res.wait_ticks) res.wait_ticks = gap;
            end else begin
              hit = k;
            end
          end
        end
        if (hit >= 0) begin
          t = ring_ids[hit];
          // rotate so the pick lands at the tail, cyclic order kept
          n = 0;
          for (int k = hit + 1; k < ring_len; k++) begin
            rotated[n] = ring_ids[k];
            n++;
          end
          for (int k = 0; k <= hit; k++) begin
            rotated[n] = ring_ids[k];
            n++;
          end
          for (int k = 0; k < ring_len; k++) ring_ids[k] = rotated[k];
          running[t] = 1'b1;
          wake_at[t] = '0;
          res.chosen_valid  = 1'b1;
          res.chosen_thread = t;
        end
      end
      default: ;  // spare codes leave everything alone and return all zeros
    endcase
    return res;
  endfunction

  task automatic push_req(input logic [rrtp_pkg::KIND_W-1:0] kind,
                          input logic [rrtp_pkg::TID_W-1:0] tid,
                          input logic prev, input logic [rrtp_pkg::TIME_W-1:0] dl,
                          input logic [rrtp_pkg::TIME_W-1:0] tnow);
    pick_req_t r;
    r.kind       = kind;
    r.thread_id  = tid;
    r.prev_valid = prev;
    r.deadline   = dl;
    r.now        = tnow;
    r.prev_src   = PREV_AS_GIVEN;
    pending_reqs.push_back(r);
  endtask

  // random words: mostly meaningful traffic around t_base, some wild times and spare codes
  task automatic queue_random_requests(input int count);
    pick_req_t r;
    int        roll;
    for (int i = 0; i < count; i++) begin
      // fields the operation ignores still carry random bits
      r.kind       = rrtp_pkg::KIND_ADD;
      r.thread_id  = rrtp_pkg::TID_W'($urandom_range(0, rrtp_pkg::MAX_THREADS - 1));
      r.prev_valid = 1'($urandom_range(0, 1));
      r.deadline   = {$urandom, $urandom};
      r.now        = {$urandom, $urandom};
      r.prev_src   = PREV_AS_GIVEN;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        r.kind = rrtp_pkg::KIND_ADD;
      end else if (roll < 33) begin
        r.kind = rrtp_pkg::KIND_REMOVE;
      end else if (roll < 50) begin
        r.kind = rrtp_pkg::KIND_SET;
        case ($urandom_range(0, 9))
          0: r.deadline = '0;
          1: r.deadline = '1;                      // infinite
          2: ;                                      // any 64-bit wake time
          3: r.deadline = t_base - $urandom_range(0, 200);
          default: r.deadline = t_base + $urandom_range(0, 1500);
        endcase
      end else if (roll < 60) begin
        r.kind = rrtp_pkg::KIND_CLEAR;
      end else if (roll < 96) begin
        r.kind = rrtp_pkg::KIND_SCHED;
        roll = $urandom_range(0, 9);
        if (roll < 5) r.prev_src = PREV_LAST_PICK;
        else if (roll < 8) r.prev_src = PREV_ANY_BUSY;
        // one in twenty keeps a random current time
        if ($urandom_range(0, 19) != 0) begin
          t_base += $urandom_range(0, 300);
          r.now = t_base;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: r.kind = KIND_RSVD5;
          1: r.kind = KIND_RSVD6;
          default: r.kind = KIND_RSVD7;
        endcase
      end
      pending_reqs.push_back(r);
    end
  endtask

  // hold off until every word is out and answered, then let the block settle
  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // slice register is only touched while nothing is in flight
  task automatic program_slice(input logic [rrtp_pkg::SLICE_W-1:0] v);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slice_len = v;
  endtask

  // input driver: offers the next pending word, holds it until it is taken
  always @(posedge clk) begin : drive_requests
    pick_req_t                  nxt;
    pick_res_t                  got;
    logic [rrtp_pkg::TID_W-1:0] busy [$];
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.kind       <= rrtp_pkg::KIND_ADD;
      in_ch.thread_id  <= '0;
      in_ch.prev_valid <= 1'b0;
      in_ch.deadline   <= '0;
      in_ch.now        <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        got = predict_picker_word(in_flight);
        expected_words.push_back(got);
        if (in_flight.kind == rrtp_pkg::KIND_SCHED) begin
          have_pick = got.chosen_valid;
          last_pick = got.chosen_thread;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 &&
            (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_reqs.pop_front();
          // previous thread resolved against the state right now, like a real caller
          if (nxt.prev_src == PREV_LAST_PICK) begin
            nxt.prev_valid = have_pick;
            nxt.thread_id  = last_pick;
          end else if (nxt.prev_src == PREV_ANY_BUSY) begin
            busy.delete();
            for (int k = 0; k < rrtp_pkg::MAX_THREADS; k++)
              if (running[k]) busy.push_back(rrtp_pkg::TID_W'(k));
            nxt.prev_valid = busy.size() != 0;
            if (busy.size() != 0) nxt.thread_id = busy[$urandom_range(0, busy.size() - 1)];
          end
          in_flight = nxt;
          in_ch.valid      <= 1'b1;
          in_ch.kind       <= nxt.kind;
          in_ch.thread_id  <= nxt.thread_id;
          in_ch.prev_valid <= nxt.prev_valid;
          in_ch.deadline   <= nxt.deadline;
          in_ch.now        <= nxt.now;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: every taken word is checked against the oldest expectation
  always @(posedge clk) begin : check_results
    pick_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_ch.chosen_valid !== want.chosen_valid) begin
            $error("chosen_valid: expected %0d, got %0d", want.chosen_valid,
                   out_ch.chosen_valid);
            mismatch_count++;
          end
          if (out_ch.chosen_thread !== want.chosen_thread) begin
            $error("chosen_thread: expected %0d, got %0d", want.chosen_thread,
                   out_ch.chosen_thread);
            mismatch_count++;
          end
          if (out_ch.wait_ticks !== want.wait_ticks) begin
            $error("wait_ticks: expected %0d, got %0d", want.wait_ticks, out_ch.wait_ticks);
            mismatch_count++;
          end
          if (out_ch.was_delayed !== want.was_delayed) begin
            $error("was_delayed: expected %0d, got %0d", want.was_delayed,
                   out_ch.was_delayed);
            mismatch_count++;
          end
          if (out_ch.refused !== want.refused) begin
            $error("refused: expected %0d, got %0d", want.refused, out_ch.refused);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, slice still at its reset value
    push_req(rrtp_pkg::KIND_SCHED, 4'd0, 1'b0, '0, '0);      // empty ring, bare slice back
    push_req(rrtp_pkg::KIND_CLEAR, 4'd5, 1'b0, '0, '0);      // never delayed
    push_req(rrtp_pkg::KIND_REMOVE, 4'd3, 1'b0, '0, '0);     // not queued, no change
    push_req(rrtp_pkg::KIND_ADD, 4'd0, 1'b0, '0, '0);
    push_req(rrtp_pkg::KIND_ADD, 4'd15, 1'b0, '0, '0);
    push_req(rrtp_pkg::KIND_ADD, 4'd0, 1'b0, '0, '0);        // duplicate, refused
    push_req(rrtp_pkg::KIND_ADD, 4'd7, 1'b0, '0, '0);
    push_req(rrtp_pkg::KIND_SET, 4'd15, 1'b0, '1, '0);       // infinite wake time
    push_req(rrtp_pkg::KIND_SET, 4'd0, 1'b0, 64'd500, '0);
    push_req(rrtp_pkg::KIND_SCHED, 4'd0, 1'b0, '0, 64'd100); // skips two sleepers
    push_req(rrtp_pkg::KIND_SCHED, 4'd7, 1'b1, '0, 64'd600); // release, wake time passed
    push_req(rrtp_pkg::KIND_SCHED, 4'd0, 1'b0, '0, 64'd700);
    push_req(rrtp_pkg::KIND_SCHED, 4'd0, 1'b0, '0, '1);      // wake time equal to now
    push_req(rrtp_pkg::KIND_SCHED, 4'd0, 1'b0, '0, '0);      // every queued thread running
    push_req(rrtp_pkg::KIND_REMOVE, 4'd0, 1'b0, '0, '0);     // running thread unlinked
    push_req(rrtp_pkg::KIND_ADD, 4'd0, 1'b0, '0, '0);        // back in, mark still set
    push_req(rrtp_pkg::KIND_SCHED, 4'd9, 1'b1, '0, 64'd5);   // release of an unknown thread
    push_req(rrtp_pkg::KIND_SET, 4'd7, 1'b0, 64'd1, '0);
    push_req(rrtp_pkg::KIND_CLEAR, 4'd7, 1'b0, '0, '0);
    push_req(rrtp_pkg::KIND_SET, 4'd4, 1'b0, 64'hA5A5_5A5A_0F0F_F0F0, '0);
    push_req(rrtp_pkg::KIND_CLEAR, 4'd4, 1'b1, '1, '1);
    push_req(KIND_RSVD5, 4'd15, 1'b1, '1, '1);               // spare codes return zeros
    push_req(KIND_RSVD6, 4'd15, 1'b1, '1, '1);
    push_req(KIND_RSVD7, 4'd15, 1'b1, '1, '1);
    push_req(rrtp_pkg::KIND_SCHED, 4'd15, 1'b1, '1, '1);

    // smallest slice: nearly every wait is capped
    program_slice(32'd1);
    t_base = '0;
    queue_random_requests(RANDOM_WORDS);

    // largest slice, no idling on either side for the whole phase
    program_slice(32'hFFFF_FFFF);
    calm_stretch = 1'b1;
    t_base = {$urandom, 32'd0};
    queue_random_requests(RANDOM_WORDS);
    drain_and_settle();
    calm_stretch = 1'b0;

    // slice comparable to deadline gaps; clock near the top of the range so it wraps
    program_slice(32'($urandom_range(1, 2000)));
    t_base = 64'hFFFF_FFFF_FFFF_F000;
    for (int i = 0; i < rrtp_pkg::MAX_THREADS + 1; i++)
      push_req(rrtp_pkg::KIND_ADD, rrtp_pkg::TID_W'(i), 1'b0, '0, '0);  // last add refused
    queue_random_requests(RANDOM_WORDS - rrtp_pkg::MAX_THREADS);

    // any 32-bit slice
    program_slice(32'($urandom_range(1, 32'hFFFF_FFFF)));
    t_base = 64'd1_000_000;
    queue_random_requests(RANDOM_WORDS);

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
